FILE: hw/rtl/pcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcce_pkg
// Shared types and constants of the piecewise calibration curve evaluator.
// ----------------------------------------------------------------------------
package pcce_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // Exponent argument clamp, in whole units.
  localparam int EXP_LIMIT = 23;
  localparam int U_W       = FRAC_BITS + 6;
  localparam int VB_W      = FRAC_BITS + 39;
  localparam int MAG_W     = 41;

  localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7653;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

  // Taylor series of exp(t): terms 1..SERIES_TERMS, two register stages per
  // term after the first one.
  localparam int SERIES_TERMS = 12;
  localparam int SERIES_REGS  = 2 * (SERIES_TERMS - 1);
  localparam int RECIP_SHIFT  = 36;

  // ceil(2^36 / n) for n = 2..12; exact quotients for 32-bit dividends.
  localparam logic [35:0] SERIES_RECIP [SERIES_TERMS-1] = '{
    36'h8_0000_0000, 36'h5_5555_5556, 36'h4_0000_0000, 36'h3_3333_3334,
    36'h2_AAAA_AAAB, 36'h2_4924_924A, 36'h2_0000_0000, 36'h1_C71C_71C8,
    36'h1_9999_999A, 36'h1_745D_1746, 36'h1_5555_5556
  };

  localparam int EXP_STAGES  = 4 + SERIES_REGS + 2;
  localparam int QUAD_STAGES = 4;
  localparam int QUAD_PAD    = EXP_STAGES - QUAD_STAGES;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_BP_FIRST  = 2'd0,
    CFG_BP_SECOND = 2'd1,
    CFG_EXP_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } eval_t;

  typedef struct packed {
    logic [1:0] seg;
    logic       is_exp;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              sat;
  } quad_res_t;

  typedef struct packed {
    logic [MAG_W-1:0]         mag;
    logic                     big;
    logic                     a_neg;
    logic                     a_zero;
    logic signed [DATA_W-1:0] d;
  } exp_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/piecewise_calibration_curve_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_calibration_curve_eval
// Three-segment calibration curve on a Q16.16 input. The block takes one
// request per cycle while the output is not stalled and returns the result
// of each evaluation; coefficient writes return nothing and take effect
// for the very next request. The pipeline depth is set by the exponential
// datapath, whose series needs two multiplier stages for each term after
// the first. An output stall holds the whole pipeline. The coefficient
// table has no clearing pass and must be written before a segment that
// uses it is evaluated.
// ----------------------------------------------------------------------------
module piecewise_calibration_curve_eval #(
  parameter int SEGMENTS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] measured_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         segment_used_o,
  output logic               saturated_o
);

  localparam int NE = pcce_pkg::EXP_STAGES;

  logic                 adv;
  logic                 front_valid;
  pcce_pkg::eval_t      front_eval;
  pcce_pkg::ctl_t       front_ctl;
  pcce_pkg::quad_res_t  quad_res;
  pcce_pkg::exp_res_t   exp_res;

  logic                 valid_q [NE];
  pcce_pkg::ctl_t       ctl_q   [NE];

  logic                 out_valid_q;
  logic [31:0]          res_q, res_d;
  logic [1:0]           seg_q;
  logic                 sat_q, sat_d;
  logic signed [42:0]   exp_mag, exp_sum;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  pcce_front #(
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .func_i           (func_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .measured_value_i (measured_value_i),
    .valid_o          (front_valid),
    .eval_o           (front_eval),
    .ctl_o            (front_ctl)
  );

  pcce_quad u_quad (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .eval_i (front_eval),
    .res_o  (quad_res)
  );

  pcce_exp u_exp (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .eval_i (front_eval),
    .res_o  (exp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NE; i++) begin
        valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= front_valid;
      for (int i = 1; i < NE; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      out_valid_q <= valid_q[NE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= front_ctl;
      for (int i = 1; i < NE; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign exp_mag = $signed({2'b00, exp_res.mag});
  assign exp_sum = (exp_res.a_neg ? -exp_mag : exp_mag) + 43'(exp_res.d);

  always_comb begin
    res_d = quad_res.res;
    sat_d = quad_res.sat;
    if (ctl_q[NE-1].is_exp) begin
      if (exp_res.a_zero) begin
        res_d = exp_res.d;
        sat_d = 1'b0;
      end else if (exp_res.big) begin
        res_d = exp_res.a_neg ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
        sat_d = 1'b1;
      end else if ((&exp_sum[42:31]) || !(|exp_sum[42:31])) begin
        res_d = exp_sum[31:0];
        sat_d = 1'b0;
      end else begin
        res_d = exp_sum[42] ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
        sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      sat_q <= sat_d;
      seg_q <= ctl_q[NE-1].seg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign segment_used_o = seg_q;
  assign saturated_o    = sat_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pcce_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcce_front
// Configuration registers, coefficient table, segment choice and the first
// pipeline register.
// ----------------------------------------------------------------------------
module pcce_front #(
  parameter int SEGMENTS = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     func_i,
  input  logic [3:0]               coef_index_i,
  input  logic signed [31:0]       coef_value_i,
  input  logic signed [31:0]       measured_value_i,
  output logic                     valid_o,
  output pcce_pkg::eval_t          eval_o,
  output pcce_pkg::ctl_t           ctl_o
);

  localparam int ROW_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  logic signed [31:0] bp_first_q, bp_second_q;
  logic [2:0]         exp_mode_q;
  logic [31:0]        coef_q [SEGMENTS][4];

  logic               wr_en;
  logic [ROW_W-1:0]   wr_row, rd_row;
  logic [1:0]         seg_raw, seg_lim;
  logic               valid_q;
  pcce_pkg::eval_t    eval_q;
  pcce_pkg::ctl_t     ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_first_q  <= '0;
      bp_second_q <= '0;
      exp_mode_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (pcce_pkg::cfg_idx_e'(cfg_index_i))
        pcce_pkg::CFG_BP_FIRST:  bp_first_q  <= cfg_wdata_i;
        pcce_pkg::CFG_BP_SECOND: bp_second_q <= cfg_wdata_i;
        pcce_pkg::CFG_EXP_MODE:  exp_mode_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Slots past the table are dropped.
  assign wr_en  = in_valid_i && adv_i && (func_i == pcce_pkg::FUNC_WRITE) &&
                  (6'(coef_index_i) < 6'(SEGMENTS * 4));
  assign wr_row = ROW_W'(coef_index_i[3:2]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_q[wr_row][coef_index_i[1:0]] <= coef_value_i;
    end
  end

  always_comb begin
    if (measured_value_i < bp_first_q || bp_first_q == '0) begin
      seg_raw = 2'd0;
    end else if (measured_value_i < bp_second_q || bp_second_q == '0) begin
      seg_raw = 2'd1;
    end else begin
      seg_raw = 2'd2;
    end
    seg_lim = (4'(seg_raw) > 4'(SEGMENTS - 1)) ? 2'(SEGMENTS - 1) : seg_raw;
  end

  assign rd_row = ROW_W'(seg_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i && (func_i == pcce_pkg::FUNC_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      eval_q.x     <= measured_value_i;
      eval_q.a     <= coef_q[rd_row][0];
      eval_q.b     <= coef_q[rd_row][1];
      eval_q.c     <= coef_q[rd_row][2];
      eval_q.d     <= coef_q[rd_row][3];
      ctl_q.seg    <= seg_lim;
      ctl_q.is_exp <= exp_mode_q[seg_lim];
    end
  end

  assign valid_o = valid_q;
  assign eval_o  = eval_q;
  assign ctl_o   = ctl_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pcce_quad.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcce_quad
// Quadratic segment a*x^2 + b*x + c, rounded and saturated, then delayed to
// line up with the exponential datapath.
// ----------------------------------------------------------------------------
module pcce_quad (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  pcce_pkg::eval_t      eval_i,
  output pcce_pkg::quad_res_t  res_o
);

  localparam int F  = pcce_pkg::FRAC_BITS;
  localparam int SH = 2 * F;

  localparam logic signed [95:0] RND_HALF = 96'sd1 <<< (SH - 1);

  logic signed [63:0] xx_full, bx_full;
  logic [62:0]        xx_q;
  logic signed [63:0] bx_q;
  logic signed [31:0] a1_q, c1_q;

  logic signed [64:0] pp_lo_d, pp_lo_q;
  logic signed [63:0] pp_hi_d, pp_hi_q;
  logic signed [95:0] lin_d, lin_q;
  logic signed [95:0] sum_d, sum_q;

  logic [95-SH-31:0]  sum_hi;
  pcce_pkg::quad_res_t res_d;
  pcce_pkg::quad_res_t res_q [pcce_pkg::QUAD_PAD+1];

  assign xx_full = eval_i.x * eval_i.x;
  assign bx_full = eval_i.b * eval_i.x;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xx_q <= xx_full[62:0];
      bx_q <= bx_full;
      a1_q <= eval_i.a;
      c1_q <= eval_i.c;
    end
  end

  // a*x^2 is split into two partial products, on the low 32 and the high 31 bits of the square.
  assign pp_lo_d = a1_q * $signed({1'b0, xx_q[31:0]});
  assign pp_hi_d = a1_q * $signed({1'b0, xx_q[62:32]});
  assign lin_d   = (96'(bx_q) <<< F) + (96'(c1_q) <<< SH) + RND_HALF;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      lin_q   <= lin_d;
    end
  end

  assign sum_d = (96'(pp_hi_q) <<< 32) + 96'(pp_lo_q) + lin_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_hi = sum_q[95:SH+31];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      res_d.res = sum_q[SH+31:SH];
      res_d.sat = 1'b0;
    end else begin
      res_d.res = sum_q[95] ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
      res_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q[0] <= res_d;
      for (int i = 1; i <= pcce_pkg::QUAD_PAD; i++) begin
        res_q[i] <= res_q[i-1];
      end
    end
  end

  assign res_o = res_q[pcce_pkg::QUAD_PAD];

endmodule
`default_nettype wire

FILE: hw/rtl/pcce_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcce_exp
// Exponential segment a*exp(b*x + c) + d: argument, base-2 split, Taylor
// series of the fraction, scaling and rounding of the magnitude.
// ----------------------------------------------------------------------------
module pcce_exp (
  input  logic                clk_i,
  input  logic                adv_i,
  input  pcce_pkg::eval_t     eval_i,
  output pcce_pkg::exp_res_t  res_o
);

  localparam int F   = pcce_pkg::FRAC_BITS;
  localparam int U_W = pcce_pkg::U_W;
  localparam int VBW = pcce_pkg::VB_W;
  localparam int NS  = pcce_pkg::SERIES_REGS;

  localparam logic signed [63:0] U_HALF = 64'sd1 <<< (F - 1);
  localparam logic signed [63:0] U_LIM  = 64'(pcce_pkg::EXP_LIMIT) <<< F;
  localparam logic [VBW-1:0]     VB_BIAS = VBW'(64) << (F + 32);
  localparam logic [63:0]        MAG_LIM = 64'd1 << 40;

  typedef struct packed {
    logic [31:0]        a_abs;
    logic               a_neg;
    logic               a_zero;
    logic signed [31:0] d;
  } side_t;

  // Argument stages.
  logic signed [63:0] bx_full, bx1_q;
  logic signed [31:0] c1_q;
  side_t              sd1_q, sd2_q, sd3_q;
  logic signed [63:0] u_full, u_sh, u_clamp;
  logic signed [U_W-1:0] u2_q;
  logic signed [U_W+33:0] uv;
  logic [VBW-1:0]     vb3_q;
  logic [31:0]        f3;
  logic [63:0]        tp;

  // Series stages, index 0 holds t and the first term.
  logic [31:0]        val_q [NS+1];
  logic [31:0]        t_q   [NS+1];
  logic [32:0]        p_q   [NS+1];
  logic signed [6:0]  k_q   [NS+1];
  side_t              sd_q  [NS+1];
  logic [63:0]        mul_prod [pcce_pkg::SERIES_TERMS-1];
  logic [67:0]        div_prod [pcce_pkg::SERIES_TERMS-1];

  // Scaling stages.
  logic [63:0]        m_q;
  logic signed [6:0]  km_q;
  side_t              sdm_q;
  logic signed [7:0]  s;
  logic [5:0]         sh;
  logic [63:0]        y;
  logic [64:0]        rnd;
  logic [63:0]        mag64;
  pcce_pkg::exp_res_t res_d, res_q;

  assign bx_full = eval_i.b * eval_i.x;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bx1_q        <= bx_full;
      c1_q         <= eval_i.c;
      sd1_q.a_abs  <= eval_i.a[31] ? 32'(-eval_i.a) : eval_i.a;
      sd1_q.a_neg  <= eval_i.a[31];
      sd1_q.a_zero <= (eval_i.a == '0);
      sd1_q.d      <= eval_i.d;
    end
  end

  // Round half up to F fraction bits, then clamp.
  always_comb begin
    u_full = bx1_q + (64'(c1_q) <<< F) + U_HALF;
    u_sh   = u_full >>> F;
    if (u_sh > U_LIM) begin
      u_clamp = U_LIM;
    end else if (u_sh < -U_LIM) begin
      u_clamp = -U_LIM;
    end else begin
      u_clamp = u_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u2_q  <= U_W'(u_clamp);
      sd2_q <= sd1_q;
    end
  end

  assign uv = u2_q * $signed({1'b0, pcce_pkg::LOG2E_Q32});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vb3_q <= VBW'(uv) + VB_BIAS;
      sd3_q <= sd2_q;
    end
  end

  // The biased integer part carries k + 64; its fraction f goes through ln 2.
  assign f3 = vb3_q[F+31:F];
  assign tp = 64'(f3) * 64'(pcce_pkg::LN2_Q32);

  always_comb begin
    for (int i = 0; i < pcce_pkg::SERIES_TERMS - 1; i++) begin
      mul_prod[i] = 64'(val_q[2*i]) * 64'(t_q[2*i]);
      div_prod[i] = 68'(val_q[2*i+1]) * 68'(pcce_pkg::SERIES_RECIP[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q[0] <= tp[63:32];
      t_q[0]   <= tp[63:32];
      p_q[0]   <= {1'b1, tp[63:32]};
      k_q[0]   <= 7'(vb3_q[VBW-1:F+32] - 7'd64);
      sd_q[0]  <= sd3_q;
      for (int i = 0; i < pcce_pkg::SERIES_TERMS - 1; i++) begin
        val_q[2*i+1] <= mul_prod[i][63:32];
        t_q[2*i+1]   <= t_q[2*i];
        p_q[2*i+1]   <= p_q[2*i];
        k_q[2*i+1]   <= k_q[2*i];
        sd_q[2*i+1]  <= sd_q[2*i];

        val_q[2*i+2] <= div_prod[i][pcce_pkg::RECIP_SHIFT+31:pcce_pkg::RECIP_SHIFT];
        t_q[2*i+2]   <= t_q[2*i+1];
        p_q[2*i+2]   <= p_q[2*i+1] +
                        33'(div_prod[i][pcce_pkg::RECIP_SHIFT+31:pcce_pkg::RECIP_SHIFT]);
        k_q[2*i+2]   <= k_q[2*i+1];
        sd_q[2*i+2]  <= sd_q[2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_q   <= 64'(sd_q[NS].a_abs) * 64'(p_q[NS]);
      km_q  <= k_q[NS];
      sdm_q <= sd_q[NS];
    end
  end

  // Scale by 2^k and round half away from zero on the magnitude.
  always_comb begin
    s     = 8'sd32 - 8'(km_q);
    sh    = 6'(s - 8'sd1);
    y     = m_q >> sh;
    rnd   = {1'b0, y} + 65'd1;
    mag64 = '0;
    res_d.big = 1'b0;
    if (s <= 8'sd0) begin
      res_d.big = 1'b1;
    end else if (s >= 8'sd65) begin
      mag64 = '0;
    end else if (s == 8'sd64) begin
      mag64 = 64'(m_q[63]);
    end else begin
      mag64 = rnd[64:1];
    end
    if (mag64 > MAG_LIM) begin
      res_d.big = 1'b1;
    end
    res_d.mag    = mag64[pcce_pkg::MAG_W-1:0];
    res_d.a_neg  = sdm_q.a_neg;
    res_d.a_zero = sdm_q.a_zero;
    res_d.d      = sdm_q.d;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pcce_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcce_checker
// Port-level checks of the calibration curve evaluator, bound to the top.
// ----------------------------------------------------------------------------
module pcce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_value_o,
  input logic [1:0]  segment_used_o,
  input logic        saturated_o
);

  // Only three segments exist.
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_used_o != 2'd3)
    else $error("segment index out of range");

  // A clipped result sits on one of the two rails.
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (result_value_o == 32'h7FFF_FFFF || result_value_o == 32'h8000_0000))
    else $error("saturated result not at a rail");

  // A blocked result must hold back new requests.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_value_o) && $stable(segment_used_o)))
    else $error("stalled result changed");

endmodule

bind piecewise_calibration_curve_eval pcce_checker u_pcce_checker (.*);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piecewise calibration curve evaluator. A
// bit-exact model of the quadratic and exponential segments predicts every
// evaluation request, while both handshakes idle and stall at random, and
// each result is compared in order of arrival.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] CFG_SPARE   = 2'd3;  // index with no register behind it
  localparam int         DRAIN_WAIT  = 40;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         RAND_ITEMS  = 1500;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         seg;
    logic               sat;
  } curve_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic [3:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] measured_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         segment_used;
  logic               saturated;

  // Shadow state of the block.
  logic signed [31:0] coef_tbl [12];
  logic signed [31:0] bp_first = '0;
  logic signed [31:0] bp_second = '0;
  logic [2:0]         exp_mode = '0;

  curve_res_t pending_results[$];
  int unsigned cycles = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          evals_sent = 0;
  int          writes_sent = 0;
  int          sat_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  always #1 clk = ~clk;

  piecewise_calibration_curve_eval DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .coef_index_i     (coef_index),
    .coef_value_i     (coef_value),
    .measured_value_i (measured_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_value_o   (result_value),
    .segment_used_o   (segment_used),
    .saturated_o      (saturated)
  );

  function automatic logic signed [31:0] clip_to_word(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return pcce_pkg::SAT_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return pcce_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] quad_value(input logic signed [31:0] x, a, b, c,
                                                   inout logic sat);
    logic signed [127:0] xw, aw, bw, cw, acc;
    xw = x;
    aw = a;
    bw = b;
    cw = c;
    acc = aw * xw * xw + bw * xw * 128'sd65536 + cw * 128'sd4294967296 + 128'sd2147483648;
    acc = acc >>> 32;
    if (acc > 128'sd2147483647) begin
      sat = 1'b1;
      return pcce_pkg::SAT_MAX;
    end
    if (acc < -128'sd2147483648) begin
      sat = 1'b1;
      return pcce_pkg::SAT_MIN;
    end
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] exp_value(input logic signed [31:0] x, a, b, c, d,
                                                  inout logic sat);
    longint      u;
    logic [63:0] vb, f, t, term, p, aa, m, mag;
    int          k, sh;
    u = longint'(b) * longint'(x) + longint'(c) * 64'sd65536;
    u = (u + 64'sd32768) >>> 16;
    if (u > 64'sd1507328) u = 64'sd1507328;     // clamp at plus and minus 23.0
    if (u < -64'sd1507328) u = -64'sd1507328;
    if (a == 0) return clip_to_word(longint'(d), sat);
    vb = 64'(u) * 64'h1_7154_7653 + (64'd64 << 48);
    k = int'(vb >> 48) - 64;
    f = (vb >> 16) & 64'hFFFF_FFFF;
    t = (f * 64'hB172_17F8) >> 32;
    term = 64'd1 << 32;
    p = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 32) / n;
      p += term;
    end
    aa = (a < 0) ? 64'(-longint'(a)) : 64'(longint'(a));
    m = aa * p;
    sh = 32 - k;
    if (sh <= 0) begin
      sat = 1'b1;
      return (a < 0) ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
    end
    if (sh > 64) mag = 0;
    else if (sh == 64) mag = m >> 63;
    else mag = ((m >> (sh - 1)) + 64'd1) >> 1;
    if (mag > (64'd1 << 40)) begin
      sat = 1'b1;
      return (a < 0) ? pcce_pkg::SAT_MIN : pcce_pkg::SAT_MAX;
    end
    return clip_to_word(((a < 0) ? -longint'(mag) : longint'(mag)) + longint'(d), sat);
  endfunction

  function automatic curve_res_t eval_curve(input logic signed [31:0] x);
    curve_res_t r;
    int         base;
    r.sat = 1'b0;
    if (x < bp_first || bp_first == 0) r.seg = 2'd0;
    else if (x < bp_second || bp_second == 0) r.seg = 2'd1;
    else r.seg = 2'd2;
    base = 4 * r.seg;
    if (exp_mode[r.seg])
      r.value = exp_value(x, coef_tbl[base], coef_tbl[base+1], coef_tbl[base+2],
                          coef_tbl[base+3], r.sat);
    else
      r.value = quad_value(x, coef_tbl[base], coef_tbl[base+1], coef_tbl[base+2], r.sat);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stall stretches, plus a long forced hold when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
      if (idle_en && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    curve_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (saturated) sat_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", result_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value || segment_used !== exp_r.seg ||
            saturated !== exp_r.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result exp %h seg %0d sat %0d, got %h seg %0d sat %0d",
                     exp_r.value, exp_r.seg, exp_r.sat, result_value, segment_used,
                     saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // One request; valid stays high afterwards unless the next call idles.
  task automatic send_req(input logic f, input logic [3:0] idx,
                          input logic signed [31:0] cv, input logic signed [31:0] mv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    coef_index = idx;
    coef_value = cv;
    measured_value = mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == pcce_pkg::FUNC_EVAL) begin
      pending_results.push_back(eval_curve(mv));
      evals_sent++;
    end else begin
      if (idx < 12) coef_tbl[idx] = cv;
      writes_sent++;
    end
    @(negedge clk);
  endtask

  task automatic write_coef(input logic [3:0] idx, input logic signed [31:0] v);
    send_req(pcce_pkg::FUNC_WRITE, idx, v, $urandom);
  endtask

  task automatic eval_x(input logic signed [31:0] x);
    send_req(pcce_pkg::FUNC_EVAL, 4'($urandom), $urandom, x);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pcce_pkg::CFG_BP_FIRST:  bp_first = v;
      pcce_pkg::CFG_BP_SECOND: bp_second = v;
      pcce_pkg::CFG_EXP_MODE:  exp_mode = v[2:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_word(input bit exp_arg);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2:       return 0;
      3:       return exp_arg ? $signed($urandom_range(0, 1 << 17)) - 32'sd65536
                              : $signed($urandom_range(0, 1 << 22)) - 32'sd2097152;
      default: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
    endcase
  endfunction

  task automatic test_directed();
    for (int i = 0; i < 12; i++) write_coef(4'(i), 32'sh0001_0000 * (i - 5));
    write_coef(4'd12, 32'sh7FFF_FFFF);     // beyond the table, dropped
    write_coef(4'd15, 32'sh8000_0000);
    eval_x(32'sh0000_0000);
    eval_x(32'sh7FFF_FFFF);
    eval_x(32'sh8000_0000);
    eval_x(-32'sd1);
    wait_drained();
    write_reg(pcce_pkg::CFG_BP_FIRST, 32'hFFFF_0000);
    write_reg(pcce_pkg::CFG_BP_SECOND, 32'h0002_0000);
    write_reg(pcce_pkg::CFG_EXP_MODE, 32'h0000_0007);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);    // no such register
    write_coef(4'd0, 0);                    // zero a: exponential gives d exactly
    write_coef(4'd5, 32'sh7FFF_FFFF);       // huge exponent, clipped
    write_coef(4'd8, -32'sd65536);
    eval_x(32'sh8000_0000);
    eval_x(32'sh0000_0000);
    eval_x(32'sh0002_0000);
    eval_x(32'sh7FFF_FFFF);
    eval_x(32'shFFFF_0000);
  endtask

  task automatic test_random(input int n);
    logic signed [31:0] x;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15)
        write_coef(4'($urandom_range(0, 15)), rand_word(1'($urandom_range(0, 1))));
      else begin
        case ($urandom_range(0, 3))
          0:       x = bp_first + $signed($urandom_range(0, 4)) - 2;
          1:       x = bp_second + $signed($urandom_range(0, 4)) - 2;
          default: x = rand_word(1'b1);
        endcase
        eval_x(x);
      end
    end
  endtask

  task automatic test_settings();
    logic [31:0] bp0, bp1;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0:       begin bp0 = 32'h8000_0000; bp1 = 32'h7FFF_FFFF; end
        1:       begin bp0 = 32'h7FFF_FFFF; bp1 = 0; end
        default: begin
          bp0 = $signed($urandom_range(0, 1 << 19)) - 32'sd262144;
          bp1 = bp0 + $urandom_range(0, 1 << 19);
        end
      endcase
      write_reg(pcce_pkg::CFG_BP_FIRST, bp0);
      write_reg(pcce_pkg::CFG_BP_SECOND, bp1);
      write_reg(pcce_pkg::CFG_EXP_MODE, (ph == 0) ? 32'd0 : 32'($urandom_range(0, 7)));
      idle_en = (ph != 3);
      test_random(RAND_ITEMS / 6);
    end
    idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back.
  task automatic test_backpressure();
    wait_drained();
    hold_left = 200;
    idle_en = 1'b0;
    test_random(80);
    idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 12; i++) coef_tbl[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_settings();
    test_backpressure();
    wait_drained();
    $display("Covered %0d evaluations and %0d coefficient writes, %0d results checked",
             evals_sent, writes_sent, results_seen);
    $display("across breakpoint and mode settings; %0d results saturated", sat_seen);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
